// ===== hdl/tfn_pkg.sv =====
// Shared constants and pipeline record types for the triangle face normal block.
// No dependencies; every other file in hdl/ imports this package.
package tfn_pkg;

  localparam int COORD_BITS  = 24;                  // vertex coordinate width, Q8.16
  localparam int EDGE_W      = COORD_BITS + 1;      // edge vector component
  localparam int PROD_W      = 2 * EDGE_W;          // one partial cross product term
  localparam int MAG_W       = PROD_W;              // cross product magnitude
  localparam int WORD_W      = 64;                  // normalization frame
  localparam int AMT_W       = 6;                   // shift amount in the frame
  localparam int NORM_STEPS  = 6;                   // 32, 16, 8, 4, 2, 1
  localparam int CM_W        = 31;                  // scaled magnitude, top bit at 30
  localparam int SQ_W        = 2 * CM_W;
  localparam int SUM_W       = 64;
  localparam int ROOT_W      = 32;
  localparam int SQRT_STEPS  = SUM_W / 2;
  localparam int FRAC_BITS   = 14;                  // normal fraction bits, Q1.14
  localparam int QUO_W       = FRAC_BITS + 1;       // quotient never exceeds 2^FRAC_BITS
  localparam int REM_W       = ROOT_W + FRAC_BITS + 1;
  localparam int OUT_W       = 16;
  localparam int IN_W        = 9 * COORD_BITS;
  localparam int RES_W       = 3 * OUT_W;

  // Leading-zero normalization record
  typedef struct packed {
    logic                        valid;
    logic                        deg;
    logic [2:0]                  neg;
    logic [2:0][WORD_W-1:0]      mag;
    logic [WORD_W-1:0]           orw;
    logic [AMT_W-1:0]            amt;
  } tfn_norm_t;

  // Digit-by-digit square root record
  typedef struct packed {
    logic                        valid;
    logic                        deg;
    logic [2:0]                  neg;
    logic [2:0][CM_W-1:0]        cm;
    logic [SUM_W-1:0]            x;
    logic [SUM_W-1:0]            root;
    logic [SUM_W-1:0]            one;
  } tfn_sqrt_t;

  // Restoring division record, three lanes sharing one divisor
  typedef struct packed {
    logic                        valid;
    logic                        deg;
    logic [2:0]                  neg;
    logic [2:0][REM_W-1:0]       rem;
    logic [REM_W-1:0]            dvs;
    logic [2:0][QUO_W-1:0]       quo;
  } tfn_div_t;

endpackage

// ===== hdl/triangle_face_normal.sv =====
// Triangle face normal: unit normal of (v1-v0) x (v2-v0) in signed Q1.14.
// Throughput: one triangle per cycle while the skid entry is empty.
// Most of the depth is the 32-cell square root chain and the 15-cell divider chain.
// A two-entry output stage (register plus skid) keeps input flowing while a result waits, until the skid fills.
// Synchronous active-high rst clears all valid bits and swap_order; no clearing pass.
// Depends on tfn_pkg, tfn_norm_cell, tfn_sqrt_cell, tfn_div_cell.
module triangle_face_normal (
  input  logic                      clk,
  input  logic                      rst,
  // configuration: swap_order
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [0:0]                cfg_data,
  // input stream
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z, third_x, third_y, third_z
  input  logic [tfn_pkg::IN_W-1:0]  s_tdata,
  // result stream
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // normal_x, normal_y, normal_z
  output logic [tfn_pkg::RES_W-1:0] m_tdata,
  // degenerate
  output logic [0:0]                m_tuser
);
  import tfn_pkg::*;

  logic swap_order;
  logic en;

  // Configuration is taken at any time; the register only steers stage 3.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      swap_order <= 1'b0;
    end else if (cfg_valid) begin
      swap_order <= cfg_data[0];
    end
  end

  // ---------------------------------------------------------------
  // Stage 1: edges e = v1 - v0 (slots 0..2) and f = v2 - v0 (slots 3..5)
  // ---------------------------------------------------------------
  logic signed [COORD_BITS-1:0] pos [9];
  logic signed [EDGE_W-1:0]     edg [6];
  logic                         edg_valid;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      pos[i] = s_tdata[i*COORD_BITS +: COORD_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edg_valid <= 1'b0;
    end else if (en) begin
      edg_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        edg[i]     <= EDGE_W'(pos[3+i]) - EDGE_W'(pos[i]);
        edg[3 + i] <= EDGE_W'(pos[6+i]) - EDGE_W'(pos[i]);
      end
    end
  end

  // ---------------------------------------------------------------
  // Stage 2: the six partial products of the cross product
  // ---------------------------------------------------------------
  logic signed [PROD_W-1:0] prod [6];
  logic                     prod_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (en) begin
      prod_valid <= edg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod[0] <= edg[1] * edg[5];
      prod[1] <= edg[2] * edg[4];
      prod[2] <= edg[2] * edg[3];
      prod[3] <= edg[0] * edg[5];
      prod[4] <= edg[0] * edg[4];
      prod[5] <= edg[1] * edg[3];
    end
  end

  // ---------------------------------------------------------------
  // Stage 3: cross product, split into sign and magnitude
  // ---------------------------------------------------------------
  logic signed [PROD_W:0] crs [3];
  tfn_norm_t              nrm_in;
  tfn_norm_t              nrm [NORM_STEPS+1];

  always_comb begin
    nrm_in       = '0;
    nrm_in.valid = prod_valid;
    nrm_in.amt   = AMT_W'(WORD_W / 2);
    for (int i = 0; i < 3; i++) begin
      crs[i]        = (PROD_W+1)'(prod[2*i]) - (PROD_W+1)'(prod[2*i+1]);
      nrm_in.neg[i] = crs[i][PROD_W] ^ swap_order;
      nrm_in.mag[i] = crs[i][PROD_W] ? WORD_W'(MAG_W'(-crs[i])) : WORD_W'(MAG_W'(crs[i]));
    end
    nrm_in.orw = nrm_in.mag[0] | nrm_in.mag[1] | nrm_in.mag[2];
    nrm_in.deg = nrm_in.orw == '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nrm[0] <= '0;
    end else if (en) begin
      nrm[0] <= nrm_in;
    end
  end

  // Shift all three magnitudes together until the largest has its top bit at the frame MSB.
  for (genvar g = 0; g < NORM_STEPS; g++) begin : g_norm
    tfn_norm_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (nrm[g]),
      .dout (nrm[g+1])
    );
  end

  // ---------------------------------------------------------------
  // Squares of the scaled magnitudes (top CM_W bits of the frame)
  // ---------------------------------------------------------------
  logic [CM_W-1:0] cm [3];
  logic [CM_W-1:0] sq_cm [3];
  logic [SQ_W-1:0] sq [3];
  logic            sq_valid;
  logic            sq_deg;
  logic [2:0]      sq_neg;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cm[i] = nrm[NORM_STEPS].mag[i][WORD_W-1 -: CM_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
    end else if (en) begin
      sq_valid <= nrm[NORM_STEPS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_deg <= nrm[NORM_STEPS].deg;
      sq_neg <= nrm[NORM_STEPS].neg;
      for (int i = 0; i < 3; i++) begin
        sq_cm[i] <= cm[i];
        sq[i]    <= SQ_W'(cm[i]) * SQ_W'(cm[i]);
      end
    end
  end

  // ---------------------------------------------------------------
  // Sum of squares, then the square root chain
  // ---------------------------------------------------------------
  tfn_sqrt_t sqr_in;
  tfn_sqrt_t sqr [SQRT_STEPS+1];

  always_comb begin
    sqr_in       = '0;
    sqr_in.valid = sq_valid;
    sqr_in.deg   = sq_deg;
    sqr_in.neg   = sq_neg;
    for (int i = 0; i < 3; i++) begin
      sqr_in.cm[i] = sq_cm[i];
    end
    sqr_in.x    = SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
    sqr_in.root = '0;
    sqr_in.one  = SUM_W'(1) << (SUM_W - 2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sqr[0] <= '0;
    end else if (en) begin
      sqr[0] <= sqr_in;
    end
  end

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    tfn_sqrt_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (sqr[g]),
      .dout (sqr[g+1])
    );
  end

  // ---------------------------------------------------------------
  // Rounded division (cm * 2^FRAC_BITS + r/2) / r in three lanes
  // ---------------------------------------------------------------
  logic [ROOT_W-1:0] root;
  tfn_div_t          div_in;
  tfn_div_t          dv [QUO_W+1];

  always_comb begin
    root         = sqr[SQRT_STEPS].root[ROOT_W-1:0];
    div_in       = '0;
    div_in.valid = sqr[SQRT_STEPS].valid;
    div_in.deg   = sqr[SQRT_STEPS].deg;
    div_in.neg   = sqr[SQRT_STEPS].neg;
    div_in.dvs   = REM_W'(root) << (QUO_W - 1);
    for (int i = 0; i < 3; i++) begin
      div_in.rem[i] = (REM_W'(sqr[SQRT_STEPS].cm[i]) << FRAC_BITS) + REM_W'(root >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= '0;
    end else if (en) begin
      dv[0] <= div_in;
    end
  end

  for (genvar g = 0; g < QUO_W; g++) begin : g_div
    tfn_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (dv[g]),
      .dout (dv[g+1])
    );
  end

  // Apply sign; degenerate triangles give a zero vector.
  logic [RES_W-1:0] res_data;
  logic [OUT_W-1:0] qmag [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qmag[i] = OUT_W'(dv[QUO_W].quo[i]);
      if (dv[QUO_W].deg) begin
        res_data[i*OUT_W +: OUT_W] = '0;
      end else if (dv[QUO_W].neg[i]) begin
        res_data[i*OUT_W +: OUT_W] = -qmag[i];
      end else begin
        res_data[i*OUT_W +: OUT_W] = qmag[i];
      end
    end
  end

  // ---------------------------------------------------------------
  // Output register plus skid entry. The whole chain advances while the
  // skid entry is empty; the enable therefore comes from a flop only.
  // ---------------------------------------------------------------
  logic             out_valid;
  logic [RES_W-1:0] out_data;
  logic             out_deg;
  logic             skid_valid;
  logic [RES_W-1:0] skid_data;
  logic             skid_deg;

  assign en       = !skid_valid;
  assign s_tready = en;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tuser  = out_deg;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !m_tready) begin
      // hold the waiting result; park a new one in the skid entry
      if (en && dv[QUO_W].valid) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= dv[QUO_W].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !m_tready) begin
      if (en) begin
        skid_data <= res_data;
        skid_deg  <= dv[QUO_W].deg;
      end
    end else if (skid_valid) begin
      out_data <= skid_data;
      out_deg  <= skid_deg;
    end else begin
      out_data <= res_data;
      out_deg  <= dv[QUO_W].deg;
    end
  end

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry full while output register empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !m_tready))
    else $error("skid entry filled without a stalled output");

  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
    else $error("degenerate result carries a nonzero normal");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !skid_valid))
    else $error("output stage not empty after reset");

endmodule

// ===== hdl/tfn_norm_cell.sv =====
// One leading-zero normalization cell: shift left by its amount if the top bits are clear.
// Depends on tfn_pkg.
module tfn_norm_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  tfn_pkg::tfn_norm_t din,
  output tfn_pkg::tfn_norm_t dout
);
  import tfn_pkg::*;

  logic [WORD_W-1:0] mask;
  logic              hit;
  tfn_norm_t         nxt;

  always_comb begin
    mask    = ~({WORD_W{1'b1}} >> din.amt);
    hit     = (din.orw & mask) == '0;
    nxt     = din;
    nxt.amt = din.amt >> 1;
    if (hit) begin
      nxt.orw = din.orw << din.amt;
      for (int i = 0; i < 3; i++) begin
        nxt.mag[i] = din.mag[i] << din.amt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout <= '0;
    end else if (en) begin
      dout <= nxt;
    end
  end

endmodule

// ===== hdl/tfn_sqrt_cell.sv =====
// One square root cell: resolves one root bit per cycle while en is high.
// Depends on tfn_pkg.
module tfn_sqrt_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  tfn_pkg::tfn_sqrt_t din,
  output tfn_pkg::tfn_sqrt_t dout
);
  import tfn_pkg::*;

  logic [SUM_W-1:0] trial;
  tfn_sqrt_t        nxt;

  always_comb begin
    trial   = din.root + din.one;
    nxt     = din;
    nxt.one = din.one >> 2;
    if (din.x >= trial) begin
      nxt.x    = din.x - trial;
      nxt.root = (din.root >> 1) + din.one;
    end else begin
      nxt.root = din.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout <= '0;
    end else if (en) begin
      dout <= nxt;
    end
  end

endmodule

// ===== hdl/tfn_div_cell.sv =====
// One restoring division cell: one quotient bit for each of the three lanes.
// Depends on tfn_pkg.
module tfn_div_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  tfn_pkg::tfn_div_t din,
  output tfn_pkg::tfn_div_t dout
);
  import tfn_pkg::*;

  tfn_div_t nxt;

  always_comb begin
    nxt     = din;
    nxt.dvs = din.dvs >> 1;
    for (int i = 0; i < 3; i++) begin
      if (din.rem[i] >= din.dvs) begin
        nxt.rem[i] = din.rem[i] - din.dvs;
        nxt.quo[i] = {din.quo[i][QUO_W-2:0], 1'b1};
      end else begin
        nxt.quo[i] = {din.quo[i][QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout <= '0;
    end else if (en) begin
      dout <= nxt;
    end
  end

endmodule
